/* rtl/lgrs_pkg.sv */
// Shared types and constants for the Life generation row stepper.
package lgrs_pkg;

  localparam int unsigned RowBits   = 64;
  localparam int unsigned WidthBits = 7;
  localparam logic [WidthBits-1:0] WidthReset = 7'd64;

  typedef logic [RowBits-1:0] row_t;

  typedef struct packed {
    row_t row_bits;
    logic last_row;
  } in_item_t;

  typedef struct packed {
    row_t next_row_bits;
    logic last_out;
  } out_item_t;

  // Results released by one input item: cnt of them, first then second.
  typedef struct packed {
    logic [1:0] cnt;
    out_item_t  first;
    out_item_t  second;
  } res_pair_t;

  // Input register contents: the three-row window plus control.
  typedef struct packed {
    row_t upper;
    row_t middle;
    row_t lower;
    logic mid_valid;
    logic last;
    row_t mask;
  } win_t;

endpackage

/* rtl/lgrs_next_gen.sv */
// Next-generation value of one row from the rows above and below it (B3/S23).
module lgrs_next_gen (
  input  lgrs_pkg::row_t up_i,
  input  lgrs_pkg::row_t mid_i,
  input  lgrs_pkg::row_t down_i,
  input  lgrs_pkg::row_t mask_i,
  output lgrs_pkg::row_t next_o
);

  lgrs_pkg::row_t up_l, up_r, mid_l, mid_r, dn_l, dn_r;
  lgrs_pkg::row_t alive;

  // _l: neighbor at column c-1, _r: neighbor at column c+1; no wrap
  assign up_l  = up_i << 1;
  assign up_r  = up_i >> 1;
  assign mid_l = mid_i << 1;
  assign mid_r = mid_i >> 1;
  assign dn_l  = down_i << 1;
  assign dn_r  = down_i >> 1;

  always_comb begin
    logic [7:0] nb;
    logic [3:0] cnt;
    alive = '0;
    for (int c = 0; c < lgrs_pkg::RowBits; c++) begin
      nb = {up_l[c], up_i[c], up_r[c], mid_l[c], mid_r[c], dn_l[c], down_i[c], dn_r[c]};
      cnt = 4'($countones(nb));
      alive[c] = (cnt == 4'd3) || ((cnt == 4'd2) && mid_i[c]);
    end
  end

  assign next_o = alive & mask_i;

endmodule

/* rtl/lgrs_out_buf.sv */
// Result register holding up to two results of one item, drained one per cycle while the output is not stalled.
module lgrs_out_buf (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  lgrs_pkg::res_pair_t pair_i,
  output logic                can_load_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output lgrs_pkg::out_item_t out_item_o
);

  logic [1:0]          cnt_q, cnt_d;
  lgrs_pkg::out_item_t a_q, a_d, b_q, b_d;
  logic                pop;

  assign pop         = (cnt_q != 2'd0) && !out_stall_i;
  assign can_load_o  = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && pop);
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_item_o  = a_q;

  always_comb begin
    cnt_d = cnt_q;
    a_d   = a_q;
    b_d   = b_q;
    if (load_i) begin
      cnt_d = pair_i.cnt;
      a_d   = pair_i.first;
      b_d   = pair_i.second;
    end else if (pop) begin
      cnt_d = cnt_q - 2'd1;
      a_d   = b_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
  end

`ifndef NO_ASSERTIONS
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("result count out of range");
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> can_load_o) else $error("load while results still pending");
`endif

endmodule

/* rtl/life_generation_row_stepper_core.sv */
// Top level of the Life generation row stepper: row window, input register, results.
// An item passes the input register; its results then pass the result register.
// Rows are accepted one per cycle while the result register can take their results;
// a bottom row releases two results (one if alone), drained by the single output port.
// Reset clears the row window, both stage valids and sets width_q to 64.
module life_generation_row_stepper_core #(
  parameter int unsigned ROW_CELLS = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  lgrs_pkg::in_item_t                  in_item_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output lgrs_pkg::out_item_t                 out_item_o,
  input  logic                                cfg_we_i,
  input  logic [lgrs_pkg::WidthBits-1:0]      cfg_wdata_i
);

  localparam logic [lgrs_pkg::WidthBits-1:0] CellsMax = lgrs_pkg::WidthBits'(ROW_CELLS);

  logic [lgrs_pkg::WidthBits-1:0] width_q;
  logic [lgrs_pkg::WidthBits-1:0] width_eff;
  lgrs_pkg::row_t                 mask;
  lgrs_pkg::row_t                 row_in;

  lgrs_pkg::row_t upper_q, upper_d, middle_q, middle_d;
  logic           mid_valid_q, mid_valid_d;

  lgrs_pkg::win_t win_q, win_d;
  logic           win_valid_q, win_valid_d;

  logic                in_acc;
  logic                can_load, adv;
  lgrs_pkg::row_t      gen_mid, gen_low;
  lgrs_pkg::res_pair_t pair;

  // active width saturates at the row size
  assign width_eff = (width_q > CellsMax) ? CellsMax : width_q;

  always_comb begin
    for (int c = 0; c < lgrs_pkg::RowBits; c++) begin
      mask[c] = lgrs_pkg::WidthBits'(c) < width_eff;
    end
  end

  assign row_in = in_item_i.row_bits & mask;

  assign adv        = win_valid_q && can_load;
  assign in_stall_o = win_valid_q && !can_load;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    upper_d     = upper_q;
    middle_d    = middle_q;
    mid_valid_d = mid_valid_q;
    win_d       = win_q;
    win_valid_d = win_valid_q && !adv;
    if (in_acc) begin
      win_d.upper     = upper_q;
      win_d.middle    = middle_q;
      win_d.lower     = row_in;
      win_d.mid_valid = mid_valid_q;
      win_d.last      = in_item_i.last_row;
      win_d.mask      = mask;
      win_valid_d     = 1'b1;
      if (in_item_i.last_row) begin
        upper_d     = '0;
        middle_d    = '0;
        mid_valid_d = 1'b0;
      end else begin
        upper_d     = mid_valid_q ? middle_q : '0;
        middle_d    = row_in;
        mid_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q     <= lgrs_pkg::WidthReset;
      upper_q     <= '0;
      middle_q    <= '0;
      mid_valid_q <= 1'b0;
      win_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        width_q <= cfg_wdata_i;
      end
      upper_q     <= upper_d;
      middle_q    <= middle_d;
      mid_valid_q <= mid_valid_d;
      win_valid_q <= win_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
  end

  // row above the newest one
  lgrs_next_gen u_gen_mid (
    .up_i   (win_q.upper),
    .mid_i  (win_q.middle),
    .down_i (win_q.lower),
    .mask_i (win_q.mask),
    .next_o (gen_mid)
  );

  // newest row as bottom row, dead row below
  lgrs_next_gen u_gen_low (
    .up_i   (win_q.mid_valid ? win_q.middle : '0),
    .mid_i  (win_q.lower),
    .down_i ('0),
    .mask_i (win_q.mask),
    .next_o (gen_low)
  );

  always_comb begin
    pair.cnt    = {1'b0, win_q.mid_valid} + {1'b0, win_q.last};
    pair.second = '{next_row_bits: gen_low, last_out: 1'b1};
    if (win_q.mid_valid) begin
      pair.first = '{next_row_bits: gen_mid, last_out: 1'b0};
    end else begin
      pair.first = '{next_row_bits: gen_low, last_out: 1'b1};
    end
  end

  lgrs_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (adv),
    .pair_i      (pair),
    .can_load_o  (can_load),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

`ifndef NO_ASSERTIONS
  a_empty_takes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !win_valid_q |-> !in_stall_o) else $error("stall with empty input register");
  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_item_i.last_row |=> !mid_valid_q && (upper_q == '0))
    else $error("row window not cleared after bottom row");
  a_last_releases: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && win_q.last |=> out_valid_o) else $error("bottom row released no result");
`endif

endmodule
